FILE: rtl/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg
// Types, constants and a helper function shared by the keypad code lock.
// ----------------------------------------------------------------------------
package kcl_pkg;

  localparam int CODE_LENGTH_DEF = 4;

  localparam int COORD_W = 10;
  localparam int EDGE_W  = 11;
  localparam int KEY_W   = 4;
  localparam int EV_W    = 3;
  localparam int DIGIT_W = 4;
  localparam int CNT_OUT_W = 3;

  localparam int GRID_COLS = 3;
  localparam int GRID_ROWS = 4;

  localparam logic [KEY_W-1:0] KEY_OK     = 4'd9;
  localparam logic [KEY_W-1:0] KEY_CANCEL = 4'd11;
  localparam logic [KEY_W-1:0] KEY_NONE   = 4'd12;

  localparam logic [EV_W-1:0] EV_NONE   = 3'd0;
  localparam logic [EV_W-1:0] EV_DIGIT  = 3'd1;
  localparam logic [EV_W-1:0] EV_ACCEPT = 3'd2;
  localparam logic [EV_W-1:0] EV_REJECT = 3'd3;
  localparam logic [EV_W-1:0] EV_SHORT  = 3'd4;
  localparam logic [EV_W-1:0] EV_CANCEL = 3'd5;
  localparam logic [EV_W-1:0] EV_FULL   = 3'd6;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PIN_CODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_GAP       = 2'd3;

  localparam logic [15:0] PIN_CODE_RST      = 16'h4321;
  localparam logic [7:0]  BUTTON_WIDTH_RST  = 8'd64;
  localparam logic [7:0]  BUTTON_HEIGHT_RST = 8'd65;
  localparam logic [5:0]  KEY_GAP_RST       = 6'd12;

  typedef struct packed {
    logic [COORD_W-1:0] touch_x;
    logic [COORD_W-1:0] touch_y;
    logic               pressed;
  } in_t;

  typedef struct packed {
    logic [EV_W-1:0]      event_code;
    logic [DIGIT_W-1:0]   key_digit;
    logic [CNT_OUT_W-1:0] entered_count;
    logic [KEY_W-1:0]     highlighted_key;
    logic                 approved;
  } out_t;

  typedef struct packed {
    logic [7:0] button_width;
    logic [7:0] button_height;
    logic [5:0] key_gap;
  } layout_t;

  // Keys 0 to 8 carry the digits 1 to 9; the digit-zero key and the
  // command keys carry zero.
  function automatic logic [DIGIT_W-1:0] key_value(input logic [KEY_W-1:0] key);
    logic [DIGIT_W-1:0] val;
    val = (key < KEY_OK) ? key + 4'd1 : 4'd0;
    return val;
  endfunction

endpackage

FILE: rtl/kcl_hit.sv
// ----------------------------------------------------------------------------
// kcl_hit
// Hit test of a touch point against the 3 x 4 key grid, strictly inside.
// ----------------------------------------------------------------------------
module kcl_hit (
  input  logic [kcl_pkg::COORD_W-1:0] touch_x,
  input  logic [kcl_pkg::COORD_W-1:0] touch_y,
  input  kcl_pkg::layout_t            layout,
  output logic [kcl_pkg::KEY_W-1:0]   key_idx
);
  import kcl_pkg::*;

  logic [EDGE_W-1:0] x_lo [GRID_COLS];
  logic [EDGE_W-1:0] x_hi [GRID_COLS];
  logic [EDGE_W-1:0] y_lo [GRID_ROWS];
  logic [EDGE_W-1:0] y_hi [GRID_ROWS];
  logic [GRID_COLS-1:0] in_col;
  logic [GRID_ROWS-1:0] in_row;
  logic [EDGE_W-1:0] px;
  logic [EDGE_W-1:0] py;
  logic [EDGE_W-1:0] w_ext;
  logic [EDGE_W-1:0] h_ext;
  logic [EDGE_W-1:0] g_ext;

  assign px    = EDGE_W'(touch_x);
  assign py    = EDGE_W'(touch_y);
  assign w_ext = EDGE_W'(layout.button_width);
  assign h_ext = EDGE_W'(layout.button_height);
  assign g_ext = EDGE_W'(layout.key_gap);

  always_comb begin
    x_lo[0] = g_ext;
    for (int c = 1; c < GRID_COLS; c++) begin
      x_lo[c] = x_lo[c-1] + w_ext + g_ext;
    end
    for (int c = 0; c < GRID_COLS; c++) begin
      x_hi[c]   = x_lo[c] + w_ext;
      in_col[c] = (x_lo[c] < px) && (px < x_hi[c]);
    end
    y_lo[0] = g_ext;
    for (int r = 1; r < GRID_ROWS; r++) begin
      y_lo[r] = y_lo[r-1] + h_ext + g_ext;
    end
    for (int r = 0; r < GRID_ROWS; r++) begin
      y_hi[r]   = y_lo[r] + h_ext;
      in_row[r] = (y_lo[r] < py) && (py < y_hi[r]);
    end
  end

  // The lowest key index wins, so the scan runs from the last key down.
  always_comb begin
    key_idx = KEY_NONE;
    for (int r = GRID_ROWS - 1; r >= 0; r--) begin
      for (int c = GRID_COLS - 1; c >= 0; c--) begin
        if (in_row[r] && in_col[c]) begin
          key_idx = KEY_W'(r * GRID_COLS + c);
        end
      end
    end
  end

endmodule

FILE: rtl/kcl_ctrl.sv
// ----------------------------------------------------------------------------
// kcl_ctrl
// Press latch, highlight, digit buffer and code compare for one sample.
// ----------------------------------------------------------------------------
module kcl_ctrl #(
  parameter int CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic                      pressed,
  input  logic [kcl_pkg::KEY_W-1:0] key_idx,
  input  logic [15:0]               pin_code,
  output kcl_pkg::out_t             result
);
  import kcl_pkg::*;

  localparam int CNT_W = $clog2(CODE_LENGTH + 1);
  localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam int PIN_W = (CODE_LENGTH * 4 > 16) ? CODE_LENGTH * 4 : 16;

  logic [DIGIT_W-1:0] digit_store_r [CODE_LENGTH];
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic               latched_r;
  logic               latched_nxt;
  logic [KEY_W-1:0]   active_r;
  logic [KEY_W-1:0]   active_nxt;
  logic               wr_en;
  logic [DIGIT_W-1:0] digit;
  logic [EV_W-1:0]    ev;
  logic               ok;
  logic               full;
  logic               match;
  logic [PIN_W-1:0]   pin_ext;

  assign pin_ext = PIN_W'(pin_code);
  assign full    = (count_r == CNT_W'(CODE_LENGTH));

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      if (digit_store_r[i] != pin_ext[(CODE_LENGTH - 1 - i) * 4 +: 4]) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    latched_nxt = latched_r;
    active_nxt  = active_r;
    count_nxt   = count_r;
    ev          = EV_NONE;
    digit       = '0;
    ok          = 1'b0;
    wr_en       = 1'b0;
    if (!pressed) begin
      latched_nxt = 1'b0;
      active_nxt  = KEY_NONE;
    end else if (!latched_r) begin
      latched_nxt = 1'b1;
      if (key_idx != KEY_NONE) begin
        active_nxt = key_idx;
        if (full) begin
          if (key_idx == KEY_OK) begin
            ok = match;
            ev = match ? EV_ACCEPT : EV_REJECT;
          end else begin
            ev = EV_FULL;
          end
          count_nxt = '0;
        end else if (key_idx == KEY_OK) begin
          ev        = EV_SHORT;
          count_nxt = '0;
        end else if (key_idx == KEY_CANCEL) begin
          ev        = EV_CANCEL;
          count_nxt = '0;
        end else begin
          digit     = key_value(key_idx);
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
          ev        = EV_DIGIT;
        end
      end
    end else if (key_idx != KEY_NONE && active_r != KEY_NONE && key_idx != active_r) begin
      active_nxt = KEY_NONE;
    end
  end

  always_comb begin
    result.event_code      = ev;
    result.key_digit       = digit;
    result.entered_count   = CNT_OUT_W'(count_nxt);
    result.highlighted_key = active_nxt;
    result.approved        = ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      latched_r <= 1'b0;
      active_r  <= KEY_NONE;
    end else if (step) begin
      count_r   <= count_nxt;
      latched_r <= latched_nxt;
      active_r  <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && wr_en) begin
      digit_store_r[count_r[IDX_W-1:0]] <= digit;
    end
  end

endmodule

FILE: rtl/touch_keypad_code_lock.sv
// ----------------------------------------------------------------------------
// touch_keypad_code_lock
// Stages: the input register holds a sample, the result register its result.
// Throughput: one sample per cycle while out_ready is high.
// Reset: synchronous, active low; clears both pipeline stages, the entry
// count, the press latch and the highlight, and loads the register defaults.
// ----------------------------------------------------------------------------
module touch_keypad_code_lock #(
  parameter int CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  kcl_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output kcl_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [kcl_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [kcl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import kcl_pkg::*;

  logic [15:0]      pin_code_r;
  layout_t          layout_r;
  logic             smp_valid_r;
  in_t              smp_r;
  logic             res_valid_r;
  out_t             res_r;
  logic             adv;
  logic [KEY_W-1:0] key_idx;
  out_t             result;

  assign adv       = smp_valid_r && (!res_valid_r || out_ready);
  assign in_ready  = !smp_valid_r || adv;
  assign out_valid = res_valid_r;
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_code_r             <= PIN_CODE_RST;
      layout_r.button_width  <= BUTTON_WIDTH_RST;
      layout_r.button_height <= BUTTON_HEIGHT_RST;
      layout_r.key_gap       <= KEY_GAP_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PIN_CODE:      pin_code_r             <= cfg_wdata[15:0];
        CFG_BUTTON_WIDTH:  layout_r.button_width  <= cfg_wdata[7:0];
        CFG_BUTTON_HEIGHT: layout_r.button_height <= cfg_wdata[7:0];
        CFG_KEY_GAP:       layout_r.key_gap       <= cfg_wdata[5:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
    end else if (in_ready) begin
      smp_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp_r <= in_data;
    end
  end

  kcl_hit u_hit (
    .touch_x (smp_r.touch_x),
    .touch_y (smp_r.touch_y),
    .layout  (layout_r),
    .key_idx (key_idx)
  );

  kcl_ctrl #(
    .CODE_LENGTH (CODE_LENGTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (adv),
    .pressed  (smp_r.pressed),
    .key_idx  (key_idx),
    .pin_code (pin_code_r),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (adv) begin
      res_valid_r <= 1'b1;
    end else if (out_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= result;
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the touch keypad code lock. A script of touch
// samples and layout writes is built at time zero: a short directed opening,
// then layout phases filled mostly with complete code entries and some noise.
// A clocked driver feeds the script over the input handshake. A clocked
// monitor compares each result transfer with the lock behavior predicted at
// input acceptance.
// ----------------------------------------------------------------------------
module tb_top;
  import kcl_pkg::*;

  localparam int COORD_MAX   = (1 << COORD_W) - 1;
  localparam int PIN_DIGITS  = CODE_LENGTH_DEF;
  localparam int KEY_COUNT   = GRID_COLS * GRID_ROWS;
  localparam int STALL_LIMIT = 2000;
  localparam int SAMPLE_GOAL = 1200;
  localparam logic [KEY_W-1:0] KEY_ZERO = 4'd10;

  typedef enum logic [1:0] {
    CMD_SAMPLE,
    CMD_WRITE,
    CMD_DRAIN
  } cmd_kind_t;

  typedef struct {
    cmd_kind_t             kind;
    in_t                   sample;
    logic [CFG_IDX_W-1:0]  addr;
    logic [CFG_DATA_W-1:0] wdata;
  } touch_cmd_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  touch_cmd_t touch_script[$];
  out_t       pending_results[$];
  int         sample_count = 0;
  int         results_owed = 0;
  int         result_index = 0;
  int         mismatch_count = 0;

  // Layout seen by the stimulus builder, ahead of the run.
  int          plan_bw = BUTTON_WIDTH_RST;
  int          plan_bh = BUTTON_HEIGHT_RST;
  int          plan_gap = KEY_GAP_RST;
  logic [15:0] plan_pin = PIN_CODE_RST;

  // Lock state and layout as the predictor tracks them during the run.
  int               lock_bw;
  int               lock_bh;
  int               lock_gap;
  logic [15:0]      lock_pin;
  logic [3:0]       lock_digits [PIN_DIGITS];
  int               lock_count;
  logic             lock_latched;
  logic [KEY_W-1:0] lock_active;

  logic                  nx_valid;
  in_t                   nx_data;
  logic                  nx_we;
  logic [CFG_IDX_W-1:0]  nx_addr;
  logic [CFG_DATA_W-1:0] nx_wdata;
  int                    in_gap;
  logic                  in_burst = 1'b0;
  int                    out_stall;
  logic                  out_burst = 1'b0;
  int                    idle_cycles = 0;
  out_t                  want;

  touch_keypad_code_lock u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [KEY_W-1:0] key_under(logic [COORD_W-1:0] x,
                                                 logic [COORD_W-1:0] y);
    int x0;
    int y0;
    for (int row = 0; row < GRID_ROWS; row++) begin
      y0 = lock_gap + row * (lock_bh + lock_gap);
      for (int col = 0; col < GRID_COLS; col++) begin
        x0 = lock_gap + col * (lock_bw + lock_gap);
        if (x0 < int'(x) && int'(x) < x0 + lock_bw && y0 < int'(y) && int'(y) < y0 + lock_bh)
          return KEY_W'(row * GRID_COLS + col);
      end
    end
    return KEY_NONE;
  endfunction

  function automatic logic [DIGIT_W-1:0] digit_on_key(logic [KEY_W-1:0] key);
    if (key < KEY_OK) return DIGIT_W'(key + 1);
    return '0;
  endfunction

  function automatic out_t advance_lock(in_t s);
    out_t             r;
    logic [KEY_W-1:0] key;
    logic             match;
    r = '0;
    if (!s.pressed) begin
      lock_latched = 1'b0;
      lock_active  = KEY_NONE;
    end else begin
      key = key_under(s.touch_x, s.touch_y);
      if (!lock_latched) begin
        lock_latched = 1'b1;
        if (key != KEY_NONE) begin
          lock_active = key;
          if (lock_count >= PIN_DIGITS) begin
            if (key == KEY_OK) begin
              match = 1'b1;
              for (int i = 0; i < PIN_DIGITS; i++)
                if (lock_digits[i] != lock_pin[(PIN_DIGITS - 1 - i) * 4 +: 4]) match = 1'b0;
              r.event_code = match ? EV_ACCEPT : EV_REJECT;
              r.approved   = match;
            end else begin
              r.event_code = EV_FULL;
            end
            lock_count = 0;
          end else if (key == KEY_OK) begin
            r.event_code = EV_SHORT;
            lock_count   = 0;
          end else if (key == KEY_CANCEL) begin
            r.event_code = EV_CANCEL;
            lock_count   = 0;
          end else begin
            r.key_digit             = digit_on_key(key);
            lock_digits[lock_count] = r.key_digit;
            lock_count++;
            r.event_code = EV_DIGIT;
          end
        end
      end else if (key != KEY_NONE && lock_active != KEY_NONE && key != lock_active) begin
        lock_active = KEY_NONE;
      end
    end
    r.entered_count   = CNT_OUT_W'(lock_count);
    r.highlighted_key = lock_active;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic int key_left(logic [KEY_W-1:0] key);
    return plan_gap + (int'(key) % GRID_COLS) * (plan_bw + plan_gap);
  endfunction

  function automatic int key_top(logic [KEY_W-1:0] key);
    return plan_gap + (int'(key) / GRID_COLS) * (plan_bh + plan_gap);
  endfunction

  function automatic in_t random_touch(logic pressed);
    in_t s;
    s.touch_x = COORD_W'($urandom_range(0, COORD_MAX));
    s.touch_y = COORD_W'($urandom_range(0, COORD_MAX));
    s.pressed = pressed;
    return s;
  endfunction

  function automatic in_t touch_on(logic [KEY_W-1:0] key);
    in_t s;
    int  xl, xh, yl, yh;
    xl = key_left(key) + 1;
    xh = key_left(key) + plan_bw - 1;
    yl = key_top(key) + 1;
    yh = key_top(key) + plan_bh - 1;
    if (xh > COORD_MAX) xh = COORD_MAX;
    if (yh > COORD_MAX) yh = COORD_MAX;
    s = random_touch(1'b1);
    if (xl <= xh && yl <= yh) begin
      s.touch_x = COORD_W'($urandom_range(xh, xl));
      s.touch_y = COORD_W'($urandom_range(yh, yl));
    end
    return s;
  endfunction

  // Mostly points on a key border, which lie outside that key.
  function automatic in_t touch_off();
    in_t              s;
    logic [KEY_W-1:0] key;
    int               edge_pos;
    key = KEY_W'($urandom_range(0, KEY_COUNT - 1));
    s = touch_on(key);
    case ($urandom_range(0, 4))
      0: edge_pos = key_left(key);
      1: edge_pos = key_left(key) + plan_bw;
      2: edge_pos = -(key_top(key) + 1);
      3: edge_pos = -(key_top(key) + plan_bh + 1);
      default: return random_touch(1'b1);
    endcase
    if (edge_pos >= 0 && edge_pos <= COORD_MAX) s.touch_x = COORD_W'(edge_pos);
    else if (edge_pos < 0 && -edge_pos - 1 <= COORD_MAX) s.touch_y = COORD_W'(-edge_pos - 1);
    else s = random_touch(1'b1);
    return s;
  endfunction

  function automatic logic [KEY_W-1:0] key_for_digit(logic [3:0] digit);
    return (digit == 0) ? KEY_ZERO : KEY_W'(digit - 1);
  endfunction

  function automatic logic [15:0] decimal_pin();
    logic [15:0] code;
    for (int i = 0; i < 4; i++) code[i * 4 +: 4] = 4'($urandom_range(0, 9));
    return code;
  endfunction

  task automatic add_sample(in_t s);
    touch_cmd_t c;
    c.kind   = CMD_SAMPLE;
    c.sample = s;
    c.addr   = '0;
    c.wdata  = '0;
    touch_script.push_back(c);
    sample_count++;
  endtask

  task automatic add_release();
    add_sample(random_touch(1'b0));
  endtask

  task automatic add_drain();
    touch_cmd_t c;
    c.kind   = CMD_DRAIN;
    c.sample = '0;
    c.addr   = '0;
    c.wdata  = '0;
    touch_script.push_back(c);
  endtask

  task automatic add_write(logic [CFG_IDX_W-1:0] addr, logic [CFG_DATA_W-1:0] wdata);
    touch_cmd_t c;
    c.kind   = CMD_WRITE;
    c.sample = '0;
    c.addr   = addr;
    c.wdata  = wdata;
    touch_script.push_back(c);
    case (addr)
      CFG_PIN_CODE:      plan_pin = wdata;
      CFG_BUTTON_WIDTH:  plan_bw  = int'(wdata[7:0]);
      CFG_BUTTON_HEIGHT: plan_bh  = int'(wdata[7:0]);
      CFG_KEY_GAP:       plan_gap = int'(wdata[5:0]);
      default: ;
    endcase
  endtask

  task automatic set_layout(logic [15:0] pin, int bw, int bh, int gap);
    add_write(CFG_PIN_CODE, pin);
    add_write(CFG_BUTTON_WIDTH, CFG_DATA_W'(bw));
    add_write(CFG_BUTTON_HEIGHT, CFG_DATA_W'(bh));
    add_write(CFG_KEY_GAP, CFG_DATA_W'(gap));
  endtask

  // One press of a key, possibly wandering while held, then the release.
  task automatic press_key(logic [KEY_W-1:0] key, int holds);
    add_sample(touch_on(key));
    repeat (holds) begin
      case ($urandom_range(0, 5))
        4: add_sample(touch_on(KEY_W'($urandom_range(0, KEY_COUNT - 1))));
        5: add_sample(touch_off());
        default: add_sample(touch_on(key));
      endcase
    end
    add_release();
  endtask

  function automatic int short_hold();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  task automatic enter_code();
    int               mode;
    int               n;
    logic [15:0]      code;
    logic [KEY_W-1:0] key;
    mode = $urandom_range(0, 9);
    if ($urandom_range(0, 1) != 0) press_key(KEY_CANCEL, 0);
    code = plan_pin;
    if (mode >= 4 || code[15:12] > 9 || code[11:8] > 9 || code[7:4] > 9 || code[3:0] > 9)
      code = decimal_pin();
    n = (mode == 6) ? $urandom_range(1, 3) : (mode == 7) ? $urandom_range(0, 3) : 4;
    if (mode == 9) begin
      add_sample(touch_off());
      add_sample(touch_on(KEY_W'($urandom_range(0, KEY_COUNT - 1))));
      add_release();
    end else begin
      for (int i = 0; i < n; i++)
        press_key(key_for_digit(code[(3 - i) * 4 +: 4]), short_hold());
      if (mode == 7) begin
        key = KEY_CANCEL;
      end else if (mode == 8) begin
        key = KEY_W'($urandom_range(0, KEY_COUNT - 2));
        if (key >= KEY_OK) key = key + 1;
      end else begin
        key = KEY_OK;
      end
      press_key(key, short_hold());
    end
  endtask

  task automatic add_noise();
    repeat ($urandom_range(1, 4)) add_sample(random_touch(1'($urandom_range(0, 1))));
    add_release();
  endtask

  task automatic build_script();
    in_t s;
    int  phase;
    int  phase_end;
    int  mid;
    logic drained;
    // Directed opening on the reset layout and code.
    s = '{touch_x: COORD_W'(COORD_MAX), touch_y: COORD_W'(COORD_MAX), pressed: 1'b0};
    add_sample(s);
    s = '{touch_x: '0, touch_y: '0, pressed: 1'b1};
    add_sample(s);
    add_sample(touch_on(4'd0));
    add_release();
    for (int i = 0; i < 4; i++) press_key(key_for_digit(plan_pin[(3 - i) * 4 +: 4]), 0);
    press_key(KEY_OK, 0);
    press_key(KEY_ZERO, 0);
    press_key(KEY_CANCEL, 0);
    press_key(KEY_OK, 0);
    add_sample(touch_on(4'd4));
    add_sample(touch_on(4'd5));
    s = '{touch_x: '0, touch_y: '0, pressed: 1'b1};
    add_sample(s);
    add_release();

    phase = 1;
    while (sample_count < SAMPLE_GOAL) begin
      case (phase)
        1: set_layout(16'h0000, 255, 255, 63);
        2: set_layout(16'hFFFF, 1, 1, 0);
        3: set_layout(16'h9999, 2, 2, 0);
        default: begin
          set_layout(($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 16'hFFFF)) :
                     decimal_pin(), $urandom_range(8, 120), $urandom_range(8, 120),
                     $urandom_range(0, 63));
        end
      endcase
      phase_end = sample_count + ((phase == 2) ? 40 : $urandom_range(120, 200));
      mid       = (sample_count + phase_end) / 2;
      drained   = 1'b0;
      while (sample_count < phase_end) begin
        if (!drained && sample_count >= mid) begin
          add_drain();
          drained = 1'b1;
        end
        case ($urandom_range(0, 19))
          14, 15, 16: press_key(KEY_W'($urandom_range(0, KEY_COUNT - 1)), $urandom_range(0, 3));
          17, 18, 19: add_noise();
          default: enter_code();
        endcase
      end
      phase++;
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    $display("tb_top mismatch: %s", msg);
  endtask

  task automatic check_field(string name, int got, int exp_val);
    if (got != exp_val)
      flag_mismatch($sformatf("result %0d %s is %0d, predicted %0d",
                              result_index, name, got, exp_val));
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_data      <= '0;
      cfg_we       <= 1'b0;
      cfg_addr     <= '0;
      cfg_wdata    <= '0;
      in_gap       = 0;
      results_owed = 0;
      lock_bw      = BUTTON_WIDTH_RST;
      lock_bh      = BUTTON_HEIGHT_RST;
      lock_gap     = KEY_GAP_RST;
      lock_pin     = PIN_CODE_RST;
      lock_count   = 0;
      lock_latched = 1'b0;
      lock_active  = KEY_NONE;
    end else begin
      nx_valid = in_valid;
      nx_data  = in_data;
      nx_we    = 1'b0;
      nx_addr  = cfg_addr;
      nx_wdata = cfg_wdata;
      if (out_valid && out_ready) results_owed--;
      if (in_valid && in_ready) begin
        pending_results.push_back(advance_lock(in_data));
        results_owed++;
        nx_valid = 1'b0;
        if ($urandom_range(0, 39) == 0) in_burst = ~in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, 14);
      end
      if (!nx_valid && touch_script.size() != 0) begin
        if (in_gap != 0) begin
          in_gap--;
        end else begin
          case (touch_script[0].kind)
            CMD_SAMPLE: begin
              nx_valid = 1'b1;
              nx_data  = touch_script[0].sample;
              void'(touch_script.pop_front());
            end
            CMD_WRITE: begin
              if (results_owed == 0) begin
                nx_we    = 1'b1;
                nx_addr  = touch_script[0].addr;
                nx_wdata = touch_script[0].wdata;
                case (nx_addr)
                  CFG_PIN_CODE:      lock_pin = nx_wdata;
                  CFG_BUTTON_WIDTH:  lock_bw  = int'(nx_wdata[7:0]);
                  CFG_BUTTON_HEIGHT: lock_bh  = int'(nx_wdata[7:0]);
                  CFG_KEY_GAP:       lock_gap = int'(nx_wdata[5:0]);
                  default: ;
                endcase
                void'(touch_script.pop_front());
              end
            end
            default: begin
              if (results_owed == 0) void'(touch_script.pop_front());
            end
          endcase
        end
      end
      in_valid  <= nx_valid;
      in_data   <= nx_data;
      cfg_we    <= nx_we;
      cfg_addr  <= nx_addr;
      cfg_wdata <= nx_wdata;
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with none predicted", result_index));
        end else begin
          want = pending_results.pop_front();
          check_field("event_code", int'(out_data.event_code), int'(want.event_code));
          check_field("key_digit", int'(out_data.key_digit), int'(want.key_digit));
          check_field("entered_count", int'(out_data.entered_count),
                      int'(want.entered_count));
          check_field("highlighted_key", int'(out_data.highlighted_key),
                      int'(want.highlighted_key));
          check_field("approved", int'(out_data.approved), int'(want.approved));
        end
        result_index++;
        if ($urandom_range(0, 39) == 0) out_burst = ~out_burst;
        out_stall = out_burst ? 0 : $urandom_range(0, 14);
      end
      if (out_stall != 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  initial begin
    build_script();
    do @(negedge clk); while (touch_script.size() != 0 || in_valid || results_owed != 0);
    repeat (8) @(negedge clk);
    if (pending_results.size() != 0)
      flag_mismatch($sformatf("%0d predicted results never arrived", pending_results.size()));
    if (mismatch_count == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule

FILE: touch_keypad_code_lock.f
rtl/kcl_pkg.sv
rtl/kcl_hit.sv
rtl/kcl_ctrl.sv
rtl/touch_keypad_code_lock.sv
tb/sv/tb_top.sv
